// File: design/two_class_contiguous_slot_allocator_defines.svh
// Assertion macros shared by the checker.
`ifndef TWO_CLASS_CONTIGUOUS_SLOT_ALLOCATOR_DEFINES_SVH
`define TWO_CLASS_CONTIGUOUS_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcsa check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TCSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcsa check failed");

`endif

// File: design/tcsa_pkg.sv
package tcsa_pkg;

  localparam int FIELD_W   = 11;
  localparam int OP_W      = 2;
  localparam int WORD_BITS = 8;
  localparam int WORD_LG   = 3;
  localparam int DEF_SLOTS = 1024;
  localparam int RST_COUNT = 1024;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOW   = 2'd1;
  localparam logic [OP_W-1:0] OP_HIGH  = 2'd2;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_GRANT  = 2'd1;
  localparam logic [1:0] ST_NOROOM = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [FIELD_W-1:0] range_start;
    logic [FIELD_W-1:0] range_end;
    logic [FIELD_W-1:0] length;
  } tcsa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] start_slot;
  } tcsa_out_t;

endpackage

// File: design/tcsa_map_mem.sv
module tcsa_map_mem import tcsa_pkg::*; #(
  parameter int DEPTH = DEF_SLOTS / WORD_BITS,
  parameter int AW    = 7
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [2*WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  output logic [2*WORD_BITS-1:0] rdata
);

  // word = {high map bits, low map bits}
  logic [2*WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/tcsa_run_scan.sv
module tcsa_run_scan import tcsa_pkg::*; #(
  parameter int SW = 11
) (
  input  logic [WORD_BITS-1:0] bits_i,
  input  logic [SW-1:0]        base_i,
  input  logic [SW-1:0]        limit_i,
  input  logic [SW-1:0]        len_i,
  input  logic [SW-1:0]        run_i,
  input  logic                 found_i,
  input  logic [SW-1:0]        start_i,
  output logic [SW-1:0]        run_o,
  output logic                 found_o,
  output logic [SW-1:0]        start_o
);

  logic [SW-1:0] r;
  logic [SW-1:0] s;
  logic [SW-1:0] st;
  logic          f;

  // first-fit over one word, bit 0 is the lowest slot
  always_comb begin
    r  = run_i;
    f  = found_i;
    st = start_i;
    s  = base_i;
    for (int j = 0; j < WORD_BITS; j++) begin
      s = base_i + SW'(j);
      if (!f && s <= limit_i) begin
        if (bits_i[j]) begin
          r = r + 1'b1;
          if (r == len_i) begin
            f  = 1'b1;
            st = s - len_i + 1'b1;
          end
        end else begin
          r = '0;
        end
      end
    end
    run_o   = r;
    found_o = f;
    start_o = st;
  end

endmodule

// File: design/two_class_contiguous_slot_allocator.sv
// channel | ports                         | beat when
// in      | in_valid/in_ready/in_data     | in_valid & in_ready
// out     | out_valid/out_ready/out_data  | out_valid & out_ready
// cfg     | cfg_we/cfg_wdata              | cfg_we
// Both maps share one memory of ceil(SLOTS/8) words, 8 slots per word.
// Request: one full scan of the memory, then a read and a write of each word marked.
// Clear: a read and a write of each word in range; a bad range or an unused opcode goes straight to the result stage.
// After reset and after each cfg write a clearing pass over every word of the memory runs.
// One item at a time; a held result stalls the next item at its result stage.
module two_class_contiguous_slot_allocator import tcsa_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcsa_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcsa_out_t          out_data,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata
);

  localparam int DEPTH = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int SWN   = $clog2(SLOTS + WORD_BITS + 1);
  localparam int SW    = (SWN > FIELD_W) ? SWN : FIELD_W;
  localparam int MW    = 2 * WORD_BITS;
  localparam int RSTC  = (RST_COUNT > SLOTS) ? SLOTS : RST_COUNT;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_MRD   = 3'd4;
  localparam logic [2:0] S_MWR   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [PW-1:0] endw_r, endw_nxt;
  logic          pend_r, pend_nxt;
  logic [SW-1:0] base_r, base_nxt;
  logic [SW-1:0] count_r, count_nxt;
  tcsa_in_t      req_r, req_nxt;
  logic [SW-1:0] lrun_r, lrun_nxt, lstart_r, lstart_nxt;
  logic [SW-1:0] hrun_r, hrun_nxt, hstart_r, hstart_nxt;
  logic          lfound_r, lfound_nxt, hfound_r, hfound_nxt;
  logic [SW-1:0] first_r, first_nxt, last_r, last_nxt;
  logic          mval_r, mval_nxt, mhigh_r, mhigh_nxt;
  tcsa_out_t     pres_r, pres_nxt;
  tcsa_out_t     res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata, mem_rdata, new_word;
  logic [SW-1:0] len_w, rs_w, re_w, cfg_w, tmp_first, sel_start, s_w;
  logic [SW-1:0] crs_m1;
  logic [SW-1:0] lrun_o, lstart_o, hrun_o, hstart_o;
  logic          lfound_o, hfound_o;

  tcsa_map_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcsa_run_scan #(.SW(SW)) u_scan_low (
    .bits_i  (mem_rdata[WORD_BITS-1:0]),
    .base_i  (base_r),
    .limit_i (count_r),
    .len_i   (len_w),
    .run_i   (lrun_r),
    .found_i (lfound_r),
    .start_i (lstart_r),
    .run_o   (lrun_o),
    .found_o (lfound_o),
    .start_o (lstart_o)
  );

  tcsa_run_scan #(.SW(SW)) u_scan_high (
    .bits_i  (mem_rdata[MW-1:WORD_BITS]),
    .base_i  (base_r),
    .limit_i (count_r),
    .len_i   (len_w),
    .run_i   (hrun_r),
    .found_i (hfound_r),
    .start_i (hstart_r),
    .run_o   (hrun_o),
    .found_o (hfound_o),
    .start_o (hstart_o)
  );

  assign len_w     = SW'(req_r.length);
  assign rs_w      = SW'(in_data.range_start);
  assign re_w      = SW'(in_data.range_end);
  assign cfg_w     = SW'(cfg_wdata);
  assign crs_m1    = rs_w - 1'b1;
  assign sel_start = (req_r.opcode == OP_HIGH && !lfound_r) ? hstart_r : lstart_r;
  assign tmp_first = sel_start - 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_comb begin
    new_word = mem_rdata;
    s_w      = base_r;
    for (int j = 0; j < WORD_BITS; j++) begin
      s_w = base_r + SW'(j);
      if (s_w >= first_r && s_w <= last_r) begin
        new_word[j] = mval_r;
        if (mhigh_r) begin
          new_word[WORD_BITS+j] = mval_r;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    endw_nxt      = endw_r;
    pend_nxt      = 1'b0;
    base_nxt      = base_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    lrun_nxt      = lrun_r;
    lstart_nxt    = lstart_r;
    lfound_nxt    = lfound_r;
    hrun_nxt      = hrun_r;
    hstart_nxt    = hstart_r;
    hfound_nxt    = hfound_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    mval_nxt      = mval_r;
    mhigh_nxt     = mhigh_r;
    pres_nxt      = pres_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r[AW-1:0];
    mem_wdata     = new_word;
    mem_raddr     = ptr_r[AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = '1;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == PW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          ptr_nxt    = '0;
          base_nxt   = SW'(1);
          lrun_nxt   = '0;
          lfound_nxt = 1'b0;
          lstart_nxt = '0;
          hrun_nxt   = '0;
          hfound_nxt = 1'b0;
          hstart_nxt = '0;
          pres_nxt.start_slot = '0;
          case (in_data.opcode)
            OP_CLEAR: begin
              pres_nxt.status = ST_CLEAR;
              state_nxt       = S_FIN;
              // valid clear: mark [range_start, range_end] free in both maps
              if (rs_w != '0 && rs_w <= re_w && re_w <= count_r) begin
                first_nxt = rs_w;
                last_nxt  = re_w;
                mval_nxt  = 1'b1;
                mhigh_nxt = 1'b1;
                ptr_nxt   = PW'(crs_m1 >> WORD_LG);
                endw_nxt  = PW'((re_w - 1'b1) >> WORD_LG);
                base_nxt  = {crs_m1[SW-1:WORD_LG], WORD_LG'(0)} + 1'b1;
                state_nxt = S_MRD;
              end
            end
            OP_LOW, OP_HIGH: begin
              state_nxt = S_SCAN;
            end
            default: begin
              pres_nxt.status = ST_NOROOM;
              state_nxt       = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ptr_r != PW'(DEPTH)) begin
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + 1'b1;
        end
        if (pend_r) begin
          lrun_nxt   = lrun_o;
          lfound_nxt = lfound_o;
          lstart_nxt = lstart_o;
          hrun_nxt   = hrun_o;
          hfound_nxt = hfound_o;
          hstart_nxt = hstart_o;
          base_nxt   = base_r + SW'(WORD_BITS);
          if (ptr_r == PW'(DEPTH)) begin
            state_nxt = S_DEC;
          end
        end
      end
      S_DEC: begin
        pres_nxt.status     = ST_NOROOM;
        pres_nxt.start_slot = '0;
        state_nxt           = S_FIN;
        if ((req_r.opcode == OP_LOW && lfound_r) || (req_r.opcode == OP_HIGH && hfound_r)) begin
          pres_nxt.status     = ST_GRANT;
          pres_nxt.start_slot = FIELD_W'(sel_start);
          first_nxt = sel_start;
          last_nxt  = sel_start + len_w - 1'b1;
          mval_nxt  = 1'b0;
          mhigh_nxt = (req_r.opcode == OP_HIGH);
          ptr_nxt   = PW'(tmp_first >> WORD_LG);
          endw_nxt  = PW'((sel_start + len_w - 2'd2) >> WORD_LG);
          base_nxt  = {tmp_first[SW-1:WORD_LG], WORD_LG'(0)} + 1'b1;
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        mem_we = 1'b1;
        if (ptr_r == endw_r) begin
          state_nxt = S_FIN;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          base_nxt  = base_r + SW'(WORD_BITS);
          state_nxt = S_MRD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          res_nxt       = pres_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_w == '0) begin
        count_nxt = SW'(1);
      end else if (cfg_w > SW'(SLOTS)) begin
        count_nxt = SW'(SLOTS);
      end else begin
        count_nxt = cfg_w;
      end
      ptr_nxt   = '0;
      state_nxt = S_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      count_r     <= SW'(RSTC);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    endw_r   <= endw_nxt;
    base_r   <= base_nxt;
    req_r    <= req_nxt;
    lrun_r   <= lrun_nxt;
    lstart_r <= lstart_nxt;
    lfound_r <= lfound_nxt;
    hrun_r   <= hrun_nxt;
    hstart_r <= hstart_nxt;
    hfound_r <= hfound_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    mval_r   <= mval_nxt;
    mhigh_r  <= mhigh_nxt;
    pres_r   <= pres_nxt;
    res_r    <= res_nxt;
  end

endmodule

// File: design/tcsa_checker.sv
`include "two_class_contiguous_slot_allocator_defines.svh"

module tcsa_checker import tcsa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input tcsa_out_t out_data
);

  `TCSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `TCSA_ASSERT_NOW(a_grant_nonzero, out_valid && out_data.status == ST_GRANT, out_data.start_slot != '0)
  `TCSA_ASSERT_NOW(a_nogrant_zero, out_valid && out_data.status != ST_GRANT, out_data.start_slot == '0)
  `TCSA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind two_class_contiguous_slot_allocator tcsa_checker u_tcsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: dv/two_class_contiguous_slot_allocator_tb.sv
`timescale 1ns / 1ps

module two_class_contiguous_slot_allocator_tb;
  import tcsa_pkg::*;

  localparam int NSLOT = 1024;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tcsa_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tcsa_out_t out_data;
  logic cfg_we = 1'b0;
  logic [FIELD_W-1:0] cfg_wdata = '0;

  two_class_contiguous_slot_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: 1 = free
  bit low_free[1:NSLOT];
  bit high_free[1:NSLOT];
  int unsigned active_slots;

  tcsa_in_t pending_items[$];
  tcsa_out_t expected_results[$];
  int mismatches = 0;
  bit no_idle = 1'b0;

  function automatic void free_every_slot();
    for (int s = 1; s <= NSLOT; s++) begin
      low_free[s] = 1'b1;
      high_free[s] = 1'b1;
    end
  endfunction

  function automatic int unsigned leftmost_run(bit use_high, int unsigned len);
    int unsigned run;
    bit f;
    run = 0;
    if (len == 0 || len > active_slots) return 0;
    for (int unsigned s = 1; s <= active_slots; s++) begin
      f = use_high ? high_free[s] : low_free[s];
      if (f) begin
        run++;
        if (run == len) return s - len + 1;
      end else begin
        run = 0;
      end
    end
    return 0;
  endfunction

  function automatic void set_run(bit use_high, int unsigned first, int unsigned len, bit v);
    for (int unsigned s = first; s < first + len && s <= active_slots; s++)
      if (use_high) high_free[s] = v; else low_free[s] = v;
  endfunction

  function automatic tcsa_out_t allocate(tcsa_in_t it);
    tcsa_out_t r;
    int unsigned rs, re, len, st;
    rs = 32'(it.range_start); re = 32'(it.range_end); len = 32'(it.length);
    r.status = ST_NOROOM;
    st = 0;
    case (it.opcode)
      OP_CLEAR: begin
        r.status = ST_CLEAR;
        if (rs >= 1 && rs <= re && re <= active_slots) begin
          set_run(1'b0, rs, re - rs + 1, 1'b1);
          set_run(1'b1, rs, re - rs + 1, 1'b1);
        end
      end
      OP_LOW: begin
        st = leftmost_run(1'b0, len);
        if (st != 0) begin
          set_run(1'b0, st, len, 1'b0);
          r.status = ST_GRANT;
        end
      end
      OP_HIGH: begin
        if (leftmost_run(1'b1, len) != 0) begin
          st = leftmost_run(1'b0, len);
          if (st == 0) st = leftmost_run(1'b1, len);
          set_run(1'b0, st, len, 1'b0);
          set_run(1'b1, st, len, 1'b0);
          r.status = ST_GRANT;
        end
      end
      default: ;
    endcase
    r.start_slot = st[FIELD_W-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(allocate(in_data));
        pending_items.pop_front();
      end
      if ((!in_valid || in_ready) && pending_items.size() > 0 &&
          (no_idle || $urandom_range(99) >= 24)) begin
        // hold the next beat only after the current one went through
        if (!(in_valid && in_ready) || pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
      out_ready <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  // monitor
  always @(posedge clk) begin
    tcsa_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status || out_data.start_slot !== want.start_slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     want.status, want.start_slot, out_data.status, out_data.start_slot);
        end
      end
    end
  end

  function automatic tcsa_in_t mk(logic [OP_W-1:0] op, int rs, int re, int len);
    tcsa_in_t it;
    it.opcode = op;
    it.range_start = rs[FIELD_W-1:0];
    it.range_end = re[FIELD_W-1:0];
    it.length = len[FIELD_W-1:0];
    return it;
  endfunction

  function automatic tcsa_in_t random_item();
    int unsigned p, n, a, b;
    tcsa_in_t it;
    p = $urandom_range(99);
    n = active_slots;
    if (p < 3) return tcsa_in_t'($bits(tcsa_in_t)'({$urandom, $urandom}));
    if (p < 38) begin
      a = $urandom_range(n, 1);
      b = $urandom_range(n, a);
      if ($urandom_range(9) == 0) b = $urandom_range(NSLOT + 1, 0);
      return mk(OP_CLEAR, a, b, $urandom_range(2047));
    end
    it = mk(p < 68 ? OP_LOW : OP_HIGH, $urandom_range(2047), $urandom_range(2047),
            $urandom_range(3) == 0 ? $urandom_range(2047) :
            $urandom_range(n < 16 ? n : n / 4, 1));
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    // leave time for a clear range of full size, which reads and writes each word
    repeat (400) @(posedge clk);
  endtask

  task automatic write_count(int unsigned v);
    int unsigned s;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[FIELD_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    s = 32'(v[FIELD_W-1:0]);
    if (s < 1) s = 1;
    if (s > NSLOT) s = NSLOT;
    active_slots = s;
    free_every_slot();
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int unsigned counts[6];
    counts = '{NSLOT, 0, 2047, 37, 1, 200};
    active_slots = RST_COUNT;
    free_every_slot();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (200) @(posedge clk);

    // directed
    pending_items.push_back(mk(OP_LOW, 0, 0, 0));
    pending_items.push_back(mk(OP_HIGH, 0, 0, 0));
    pending_items.push_back(mk(OP_LOW, 0, 0, 1025));
    pending_items.push_back(mk(OP_HIGH, 0, 0, 2047));
    pending_items.push_back(mk(OP_UNUSED, 2047, 2047, 2047));
    pending_items.push_back(mk(OP_LOW, 0, 0, 10));
    pending_items.push_back(mk(OP_HIGH, 0, 0, 5));
    pending_items.push_back(mk(OP_HIGH, 0, 0, 1009));
    pending_items.push_back(mk(OP_LOW, 0, 0, 1009));
    pending_items.push_back(mk(OP_HIGH, 0, 0, 1009));
    pending_items.push_back(mk(OP_CLEAR, 0, 5, 0));
    pending_items.push_back(mk(OP_CLEAR, 9, 3, 0));
    pending_items.push_back(mk(OP_CLEAR, 1, 1025, 0));
    pending_items.push_back(mk(OP_CLEAR, 3, 8, 0));
    pending_items.push_back(mk(OP_LOW, 0, 0, 6));
    pending_items.push_back(mk(OP_CLEAR, 1, 1024, 2047));
    pending_items.push_back(mk(OP_LOW, 0, 0, 1024));
    pending_items.push_back(mk(OP_HIGH, 0, 0, 1024));
    pending_items.push_back(mk(OP_CLEAR, 1024, 1024, 0));
    pending_items.push_back(mk(OP_HIGH, 0, 0, 1));
    wait_drained();

    foreach (counts[k]) begin
      write_count(counts[k]);
      no_idle = (k == 3);
      for (int i = 0; i < 135; i++) pending_items.push_back(random_item());
      wait_drained();
    end

    if (mismatches == 0) $display("two_class_contiguous_slot_allocator_tb OK");
    else $display("two_class_contiguous_slot_allocator_tb NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("two_class_contiguous_slot_allocator_tb NOT OK");
    $finish;
  end

endmodule
